// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; included by the checker only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define FSSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FSSP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fssp_pkg.sv =====
// Package for the faded segment sample player: constants, types, mu-law decode.
// Depends on nothing.
`default_nettype none
package fssp_pkg;

  localparam int BLOCK_SAMPLES = 128;
  localparam int MAX_WORD_OUT  = 16;
  localparam int BLK_CNT_W     = $clog2(BLOCK_SAMPLES + MAX_WORD_OUT);
  localparam int TBL_DEPTH     = 257;
  localparam int TBL_AW        = 9;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] OP_TBL_WR = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MIX,
    ST_GAIN,
    ST_PROD,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic       tbl_wr;
    logic       start;
    logic       div_step;
    logic       word_ld;
    logic       mix;
    logic       gain;
    logic       prod;
    logic       next_src;
    logic [1:0] src_idx;
    logic [2:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic       playing;
    logic       pcm;
    logic [1:0] lg;
    logic       fin_pred;
  } dp_stat_t;

  function automatic logic signed [15:0] mulaw_decode(input logic [7:0] b);
    logic [7:0]  u;
    logic [15:0] base;
    logic [15:0] mag;
    u    = ~b;
    base = {9'd0, u[3:0], 3'd0} + 16'h0084;
    mag  = (base << u[6:4]) - 16'h0084;
    return u[7] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage
`default_nettype wire

// ===== sv/fssp_if.sv =====
// Valid/ready channel interfaces for input items and result samples.
// Depends on nothing.
`default_nettype none
interface fssp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [8:0]         table_index;
  logic signed [15:0] table_value;
  logic [2:0]         format;
  logic [23:0]        seg_len;
  logic [31:0]        data_word;
  modport source (output valid, operation, table_index, table_value, format,
                  seg_len, data_word, input ready);
  modport sink (input valid, operation, table_index, table_value, format,
                seg_len, data_word, output ready);
endinterface

interface fssp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  logic               finished;
  modport source (output valid, sample, last, finished, input ready);
  modport sink (input valid, sample, last, finished, output ready);
endinterface
`default_nettype wire

// ===== sv/fssp_datapath.sv =====
// Datapath: window table, phase step divider, decode, interpolation, fade.
// Depends on fssp_pkg.
`default_nettype none
module fssp_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fssp_pkg::dp_cmd_t    cmd,
  output fssp_pkg::dp_stat_t        stat,
  input  wire logic [8:0]           table_index,
  input  wire logic signed [15:0]   table_value,
  input  wire logic [2:0]           format,
  input  wire logic [23:0]          seg_len,
  input  wire logic [31:0]          data_word,
  output logic signed [15:0]        sample
);
  import fssp_pkg::*;

  logic [15:0] tbl [0:TBL_DEPTH-1];
  logic signed [15:0] rd0_r, rd1_r;

  logic signed [15:0] prev_r, v_r, gain_r, sample_r;
  logic [31:0] phase_r, step_r, word_r;
  logic [23:0] rem_r, len_r, drem_r;
  logic [2:0]  fmt_r;
  logic        play_r;
  logic [BLK_CNT_W-1:0] blk_r;
  logic [15:0] scale_r;

  logic [1:0] lg;
  logic [2:0] fct;
  logic       pcm;
  logic [4:0] nout;
  logic [BLK_CNT_W-1:0] blk_sum;
  logic [23:0] consumed;
  logic        blk_close;
  logic        fin;
  logic signed [15:0] src;
  logic signed [19:0] mix;
  logic signed [15:0] v;
  logic [32:0] phase_sum;
  logic [31:0] phase_nxt;
  logic [24:0] dsh;
  logic        dge;
  logic signed [16:0] diff;
  logic signed [33:0] gterm;
  logic signed [33:0] gsum;
  logic signed [31:0] prod;
  logic [TBL_AW-1:0] ra0, ra1;

  assign lg   = (fmt_r[2:1] > 2'd2) ? 2'd2 : fmt_r[2:1];
  assign fct  = 3'd1 << lg;
  assign pcm  = fmt_r[0];
  assign nout = (pcm ? 5'd2 : 5'd4) << lg;

  assign blk_sum   = blk_r + BLK_CNT_W'(nout);
  assign blk_close = blk_sum >= BLK_CNT_W'(BLOCK_SAMPLES);
  assign consumed  = 24'(BLOCK_SAMPLES) >> lg;
  assign fin       = blk_close && !(rem_r > consumed);

  assign stat = '{playing: play_r, pcm: pcm, lg: lg, fin_pred: fin};

  // source sample for the current slot
  always_comb begin
    if (pcm) src = cmd.src_idx[0] ? $signed(word_r[31:16]) : $signed(word_r[15:0]);
    else     src = mulaw_decode(word_r[cmd.src_idx*8 +: 8]);
  end

  assign mix = prev_r * $signed({1'b0, fct - cmd.k}) + src * $signed({1'b0, cmd.k});
  assign v   = 16'(mix >>> lg);

  assign phase_sum = {1'b0, phase_r} + {1'b0, step_r};
  assign phase_nxt = (phase_sum[32] || (phase_sum[31:0] == 32'hFFFF_FFFF)) ?
                     32'hFFFF_FFFF : phase_sum[31:0];

  // restoring division of all-ones by the length; length 0 yields all-ones
  assign dsh = {drem_r, 1'b1};
  assign dge = dsh >= {1'b0, len_r};

  assign ra0 = {1'b0, phase_r[31:24]};
  assign ra1 = ra0 + 9'd1;

  // gain = v1 + ((v2 - v1) * scale) >> 16, floor
  assign diff  = rd1_r - rd0_r;
  assign gterm = diff * $signed({1'b0, scale_r});
  assign gsum  = {{2{rd0_r[15]}}, rd0_r, 16'd0} + gterm;
  assign prod  = v_r * gain_r;

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && (table_index <= 9'(TBL_DEPTH - 1))) tbl[table_index] <= table_value;
    if (cmd.mix) begin
      rd0_r <= tbl[ra0];
      rd1_r <= tbl[ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      phase_r <= '0;
      step_r <= '0;
      rem_r <= '0;
      fmt_r <= '0;
      play_r <= 1'b0;
      blk_r <= '0;
    end else begin
      if (cmd.start) begin
        fmt_r   <= format;
        prev_r  <= '0;
        phase_r <= '0;
        step_r  <= '0;
        rem_r   <= seg_len;
        blk_r   <= '0;
        play_r  <= format <= 3'd5;
      end
      if (cmd.div_step) step_r <= {step_r[30:0], dge};
      if (cmd.word_ld) begin
        if (blk_close) begin
          blk_r <= '0;
          if (fin) play_r <= 1'b0;
          else     rem_r  <= rem_r - consumed;
        end else begin
          blk_r <= blk_sum;
        end
      end
      if (cmd.mix) phase_r <= phase_nxt;
      if (cmd.next_src) prev_r <= src;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      len_r  <= seg_len;
      drem_r <= '0;
    end
    if (cmd.div_step) drem_r <= dge ? 24'(dsh - {1'b0, len_r}) : dsh[23:0];
    if (cmd.word_ld) word_r <= data_word;
    if (cmd.mix) begin
      v_r     <= v;
      scale_r <= phase_r[23:8];
    end
    if (cmd.gain) gain_r <= gsum[31:16];
    if (cmd.prod) sample_r <= prod[30:15];
  end

  assign sample = sample_r;
endmodule
`default_nettype wire

// ===== sv/fssp_ctrl.sv =====
// Controller: accepts items, sequences the divider and per-sample steps.
// Depends on fssp_pkg.
`default_nettype none
module fssp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_op,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_last,
  output logic                    out_finished,
  output fssp_pkg::dp_cmd_t       cmd,
  input  wire fssp_pkg::dp_stat_t stat
);
  import fssp_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] k_r, k_nxt;
  logic       fin_r, fin_nxt;
  logic       acc, slot_end, word_end;
  logic [2:0] fct;

  assign acc      = in_valid && in_ready;
  assign fct      = 3'd1 << stat.lg;
  assign slot_end = k_r == fct;
  assign word_end = slot_end && (idx_r == (stat.pcm ? 2'd1 : 2'd3));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      k_r <= 3'd1;
      fin_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      k_r <= k_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    k_nxt = k_r;
    fin_nxt = fin_r;
    cmd = '0;
    cmd.src_idx = idx_r;
    cmd.k = k_r;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (acc) begin
          unique case (in_op)
            OP_TBL_WR: cmd.tbl_wr = 1'b1;
            OP_START: begin
              cmd.start = 1'b1;
              cnt_nxt = '0;
              state_nxt = ST_DIV;
            end
            OP_DATA: begin
              if (stat.playing) begin
                cmd.word_ld = 1'b1;
                fin_nxt = stat.fin_pred;
                idx_nxt = '0;
                k_nxt = 3'd1;
                state_nxt = ST_MIX;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_IDLE;
      end
      ST_MIX: begin
        cmd.mix = 1'b1;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain = 1'b1;
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (slot_end) begin
            cmd.next_src = 1'b1;
            k_nxt = 3'd1;
            idx_nxt = idx_r + 1'b1;
          end else begin
            k_nxt = k_r + 1'b1;
          end
          state_nxt = word_end ? ST_IDLE : ST_MIX;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_last = word_end;
  assign out_finished = fin_r;
endmodule
`default_nettype wire

// ===== sv/faded_segment_sample_player_core.sv =====
// Top level of the faded segment sample player: controller plus datapath.
// Depends on fssp_pkg, fssp_if, fssp_ctrl, fssp_datapath.
//
//   channel | dir | beat contents
//   in_ch   | in  | operation, table_index, table_value, format, seg_len, data_word
//   out_ch  | out | sample, last, finished
//
// Items are accepted in the idle state. A data word then steps each sample through
// mix/table read, gain, product and output, waiting in output during any output stall;
// a word gives 2 to 16 samples. A start item then runs the phase step divider; a table
// write is done on acceptance.
// One item is worked at a time; in_ch.ready is high only when idle.
// Synchronous active-low reset; the window table is not cleared.
`default_nettype none
module faded_segment_sample_player_core (
  input  wire logic clk,
  input  wire logic rst_n,
  fssp_in_if.sink   in_ch,
  fssp_out_if.source out_ch
);
  import fssp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fssp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_op        (in_ch.operation),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_last     (out_ch.last),
    .out_finished (out_ch.finished),
    .cmd          (cmd),
    .stat         (stat)
  );

  fssp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .table_index    (in_ch.table_index),
    .table_value    (in_ch.table_value),
    .format         (in_ch.format),
    .seg_len        (in_ch.seg_len),
    .data_word      (in_ch.data_word),
    .sample         (out_ch.sample)
  );
endmodule
`default_nettype wire

// ===== sv/fssp_checker.sv =====
// Port-level checks for the sample player, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fssp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  `FSSP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out beat dropped")
  `FSSP_ASSERT(a_no_overlap, clk, rst_n, out_valid |-> !in_ready, "input taken during output")
  `FSSP_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "output after reset")
  `FSSP_ASSERT(a_last_idle, clk, rst_n, out_valid && out_ready && out_last |=> in_ready, "busy after last")
endmodule

bind faded_segment_sample_player_core fssp_checker u_fssp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last)
);
`default_nettype wire
